### rtl/core/tsu_pkg.sv
`timescale 1ns / 1ps

package tsu_pkg;

    // Default table geometry
    localparam int COLUMN_BINS_DEF = 10;
    localparam int ROW_BINS_DEF    = 10;
    localparam int MOVE_COUNT_DEF  = 3;

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPLORE_RATE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEARN_RATE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISCOUNT     = 2'd2;

    localparam logic [16:0] EXPLORE_RATE_RESET = 17'd65536;
    localparam logic [15:0] LEARN_RATE_RESET   = 16'd6554;
    localparam logic [15:0] DISCOUNT_RESET     = 16'd58982;

    typedef struct packed {
        logic              episode_start;
        logic signed [7:0] reward;
        logic [3:0]        next_column_bin;
        logic [3:0]        next_obstacle_column_bin;
        logic [3:0]        next_obstacle_row_bin;
        logic [15:0]       explore_draw;
        logic [1:0]        random_move;
    } tsu_item_t;

    typedef struct packed {
        logic [1:0]         chosen_move;
        logic               explored;
        logic signed [15:0] updated_value;
    } tsu_result_t;

    // Learning coefficients handed from the front to the back
    typedef struct packed {
        logic [15:0] learn_rate;
        logic [15:0] discount;
    } tsu_coef_t;

endpackage

### rtl/core/tsu_front.sv
`timescale 1ns / 1ps

module tsu_front
    import tsu_pkg::*;
#(
    parameter int COLUMN_BINS = COLUMN_BINS_DEF,
    parameter int ROW_BINS    = ROW_BINS_DEF,
    parameter int MOVE_COUNT  = MOVE_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tsu_item_t              s_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   clearing,
    output logic                   job_valid,
    input  logic                   job_ready,
    output logic [$clog2(COLUMN_BINS*COLUMN_BINS*ROW_BINS)+$clog2(MOVE_COUNT)+9:0] job_data,
    output tsu_coef_t              coef
);

    localparam int STATE_W = $clog2(COLUMN_BINS * COLUMN_BINS * ROW_BINS);
    localparam int MOVE_W  = $clog2(MOVE_COUNT);

    logic [16:0]        explore_rate_reg;
    tsu_coef_t          coef_reg;
    logic [STATE_W-1:0] col_s;
    logic [STATE_W-1:0] ocol_s;
    logic [STATE_W-1:0] orow_s;
    logic [STATE_W-1:0] state_idx;
    logic [MOVE_W-1:0]  rmove;
    logic               explored;

    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            explore_rate_reg    <= EXPLORE_RATE_RESET;
            coef_reg.learn_rate <= LEARN_RATE_RESET;
            coef_reg.discount   <= DISCOUNT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_EXPLORE_RATE: explore_rate_reg    <= cfg_data;
                CFG_LEARN_RATE:   coef_reg.learn_rate <= cfg_data[15:0];
                CFG_DISCOUNT:     coef_reg.discount   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Saturate the bins, fold them into one state index, decide on exploring
    always_comb begin
        col_s  = (int'(s_data.next_column_bin) >= COLUMN_BINS) ?
                 STATE_W'(COLUMN_BINS - 1) : STATE_W'(s_data.next_column_bin);
        ocol_s = (int'(s_data.next_obstacle_column_bin) >= COLUMN_BINS) ?
                 STATE_W'(COLUMN_BINS - 1) : STATE_W'(s_data.next_obstacle_column_bin);
        orow_s = (int'(s_data.next_obstacle_row_bin) >= ROW_BINS) ?
                 STATE_W'(ROW_BINS - 1) : STATE_W'(s_data.next_obstacle_row_bin);
        state_idx = (col_s * STATE_W'(COLUMN_BINS) + ocol_s) * STATE_W'(ROW_BINS) + orow_s;
        rmove = (int'(s_data.random_move) >= MOVE_COUNT) ?
                MOVE_W'(MOVE_COUNT - 1) : MOVE_W'(s_data.random_move);
        explored = {1'b0, s_data.explore_draw} < explore_rate_reg;
    end

    assign job_valid = s_valid && !clearing;
    assign s_ready   = job_ready && !clearing;
    assign job_data  = {s_data.episode_start, s_data.reward, explored, rmove, state_idx};

endmodule

### rtl/core/tsu_queue.sv
`timescale 1ns / 1ps

module tsu_queue
    import tsu_pkg::*;
#(
    parameter int DATA_W = 16,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push_fire, pop_fire})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/tsu_back.sv
`timescale 1ns / 1ps

module tsu_back
    import tsu_pkg::*;
#(
    parameter int COLUMN_BINS = COLUMN_BINS_DEF,
    parameter int ROW_BINS    = ROW_BINS_DEF,
    parameter int MOVE_COUNT  = MOVE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    output logic        job_ready,
    input  logic [$clog2(COLUMN_BINS*COLUMN_BINS*ROW_BINS)+$clog2(MOVE_COUNT)+9:0] job_data,
    input  tsu_coef_t   coef,
    output logic        clearing,
    output logic        m_valid,
    input  logic        m_ready,
    output tsu_result_t m_data
);

    localparam int STATE_COUNT = COLUMN_BINS * COLUMN_BINS * ROW_BINS;
    localparam int TABLE_DEPTH = STATE_COUNT * MOVE_COUNT;
    localparam int STATE_W     = $clog2(STATE_COUNT);
    localparam int MOVE_W      = $clog2(MOVE_COUNT);
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int JOB_W       = STATE_W + MOVE_W + 10;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_SCAN  = 8'b0000_0100,
        ST_DRAIN = 8'b0000_1000,
        ST_MUL1  = 8'b0001_0000,
        ST_DIFF  = 8'b0010_0000,
        ST_MUL2  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } tsu_state_t;

    tsu_state_t state_reg, state_next;

    logic signed [15:0] value_mem [TABLE_DEPTH];
    logic signed [15:0] rd_data_reg;

    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [STATE_W-1:0] held_state_reg;
    logic [MOVE_W-1:0]  held_move_reg;
    logic [MOVE_W-1:0]  scan_idx_reg;
    logic               rd_held_reg;
    logic               rd_scan_reg;
    logic               rd_first_reg;
    logic [MOVE_W-1:0]  rd_move_reg;
    logic               m_valid_reg;

    logic               w_start_reg;
    logic signed [7:0]  w_reward_reg;
    logic               w_expl_reg;
    logic [MOVE_W-1:0]  w_rmove_reg;
    logic [STATE_W-1:0] w_state_reg;
    logic signed [15:0] q_reg;
    logic signed [15:0] best_val_reg;
    logic [MOVE_W-1:0]  best_move_reg;
    logic signed [32:0] prod1_reg;
    logic signed [18:0] diff_reg;
    logic signed [35:0] prod2_reg;
    tsu_result_t        m_data_reg;

    logic               pop_fire;
    logic               out_free;
    logic               done_fire;
    logic [MOVE_W-1:0]  scan_move;
    logic               scan_last;
    logic [ADDR_W-1:0]  held_addr;
    logic [ADDR_W-1:0]  scan_addr;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic signed [15:0] mem_wdata;

    logic signed [32:0] prod1_rnd;
    logic signed [16:0] gamma_term;
    logic signed [17:0] target;
    logic signed [18:0] diff_next;
    logic signed [35:0] prod2_rnd;
    logic signed [19:0] step;
    logic signed [20:0] new_sum;
    logic signed [15:0] sat_value;
    tsu_result_t        result;

    assign clearing  = (state_reg == ST_CLEAR);
    assign job_ready = (state_reg == ST_IDLE);
    assign pop_fire  = job_valid && job_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign done_fire = (state_reg == ST_DONE) && out_free;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign scan_move = w_expl_reg ? w_rmove_reg : scan_idx_reg;
    assign scan_last = w_expl_reg || (scan_idx_reg == MOVE_W'(MOVE_COUNT - 1));
    assign held_addr = ADDR_W'(held_state_reg) * ADDR_W'(MOVE_COUNT) + ADDR_W'(held_move_reg);
    assign scan_addr = ADDR_W'(w_state_reg) * ADDR_W'(MOVE_COUNT) + ADDR_W'(scan_move);

    assign mem_re    = pop_fire || (state_reg == ST_SCAN);
    assign mem_raddr = (state_reg == ST_SCAN) ? scan_addr : held_addr;
    assign mem_we    = clearing || (done_fire && !w_start_reg);
    assign mem_waddr = clearing ? clr_addr_reg : held_addr;
    assign mem_wdata = clearing ? 16'sd0 : sat_value;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            value_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= value_mem[mem_raddr];
        end
    end

    // Target and difference from the discounted product (round half up)
    always_comb begin
        prod1_rnd  = prod1_reg + 33'sd32768;
        gamma_term = prod1_rnd[32:16];
        target     = $signed({{2{w_reward_reg[7]}}, w_reward_reg, 8'h00})
                   + $signed({gamma_term[16], gamma_term});
        diff_next  = $signed({target[17], target}) - $signed({{3{q_reg[15]}}, q_reg});
    end

    // Step, new value and saturation
    always_comb begin
        prod2_rnd = prod2_reg + 36'sd32768;
        step      = prod2_rnd[35:16];
        new_sum   = $signed({{5{q_reg[15]}}, q_reg}) + $signed({step[19], step});
        if (new_sum > 21'sd32767) begin
            sat_value = 16'sh7FFF;
        end else if (new_sum < -21'sd32768) begin
            sat_value = 16'sh8000;
        end else begin
            sat_value = new_sum[15:0];
        end
        result.chosen_move   = 2'(best_move_reg);
        result.explored      = w_expl_reg;
        result.updated_value = w_start_reg ? 16'sd0 : sat_value;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (job_valid) state_next = ST_SCAN;
            ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            held_state_reg <= '0;
            held_move_reg  <= '0;
            scan_idx_reg   <= '0;
            rd_held_reg    <= 1'b0;
            rd_scan_reg    <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_move_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (pop_fire) begin
                scan_idx_reg <= '0;
            end else if (state_reg == ST_SCAN) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            // tag the read in flight
            rd_held_reg  <= pop_fire;
            rd_scan_reg  <= (state_reg == ST_SCAN);
            rd_first_reg <= w_expl_reg || (scan_idx_reg == '0);
            rd_move_reg  <= scan_move;
            if (done_fire) begin
                held_state_reg <= w_state_reg;
                held_move_reg  <= best_move_reg;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            w_state_reg  <= job_data[STATE_W-1:0];
            w_rmove_reg  <= job_data[STATE_W +: MOVE_W];
            w_expl_reg   <= job_data[STATE_W + MOVE_W];
            w_reward_reg <= job_data[STATE_W + MOVE_W + 1 +: 8];
            w_start_reg  <= job_data[JOB_W-1];
        end
        if (rd_held_reg) begin
            q_reg <= rd_data_reg;
        end
        // strict compare in ascending order keeps the lowest index on ties
        if (rd_scan_reg && (rd_first_reg || (rd_data_reg > best_val_reg))) begin
            best_val_reg  <= rd_data_reg;
            best_move_reg <= rd_move_reg;
        end
        if (state_reg == ST_MUL1) begin
            prod1_reg <= $signed({1'b0, coef.discount}) * best_val_reg;
        end
        if (state_reg == ST_DIFF) begin
            diff_reg <= diff_next;
        end
        if (state_reg == ST_MUL2) begin
            prod2_reg <= $signed({1'b0, coef.learn_rate}) * diff_reg;
        end
        if (done_fire) begin
            m_data_reg <= result;
        end
    end

endmodule

### rtl/core/tabular_sarsa_update.sv
`timescale 1ns / 1ps

// Tabular SARSA engine with epsilon-greedy move choice. Each input beat carries
// the reward for the last transition, the next quantised state and two random
// draws; each yields exactly one result beat with the chosen move, whether it
// was explored, and the new Q8.8 value written for the held state and move
// (zero for an episode-start beat, which loads the state without an update).
// After reset the value table is swept to zero, one entry per cycle, during
// which s_ready stays low; configuration writes are taken throughout. The
// front classifies beats and parks up to two in a queue, so the input side
// keeps moving while the engine works or a result waits. For each beat the
// single read port of the table fetches the held value and then the next
// state's moves one at a time, only the random move on an explored beat,
// followed by the two registered multiply stages for gamma and alpha and the
// write-back.
module tabular_sarsa_update
    import tsu_pkg::*;
#(
    parameter int COLUMN_BINS = COLUMN_BINS_DEF,
    parameter int ROW_BINS    = ROW_BINS_DEF,
    parameter int MOVE_COUNT  = MOVE_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tsu_item_t              s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tsu_result_t            m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Job word: start, reward, explored flag, random move, state index
    localparam int STATE_W = $clog2(COLUMN_BINS * COLUMN_BINS * ROW_BINS);
    localparam int MOVE_W  = $clog2(MOVE_COUNT);
    localparam int JOB_W   = STATE_W + MOVE_W + 10;

    logic             clearing;
    tsu_coef_t        coef;
    logic             fj_valid;
    logic             fj_ready;
    logic [JOB_W-1:0] fj_data;
    logic             bj_valid;
    logic             bj_ready;
    logic [JOB_W-1:0] bj_data;

    // Accept and classify beats, hold the configuration registers
    tsu_front #(
        .COLUMN_BINS (COLUMN_BINS),
        .ROW_BINS    (ROW_BINS),
        .MOVE_COUNT  (MOVE_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job_data  (fj_data),
        .coef      (coef)
    );

    // Decouple front from back
    tsu_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_data  (fj_data),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_data   (bj_data)
    );

    // Table lookups, greedy scan, update arithmetic and result register
    tsu_back #(
        .COLUMN_BINS (COLUMN_BINS),
        .ROW_BINS    (ROW_BINS),
        .MOVE_COUNT  (MOVE_COUNT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job_data  (bj_data),
        .coef      (coef),
        .clearing  (clearing),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### rtl/core/tsu_checker.sv
`timescale 1ns / 1ps

module tsu_checker
    import tsu_pkg::*;
#(
    parameter int MOVE_COUNT = MOVE_COUNT_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input tsu_result_t m_data
);

    logic [3:0] pending_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    // Count beats taken in but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            case ({in_beat, out_beat})
                2'b10:   pending_reg <= pending_reg + 1'b1;
                2'b01:   pending_reg <= pending_reg - 1'b1;
                default: pending_reg <= pending_reg;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != '0)
        else $error("result beat without an accepted input beat");

    a_move_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(m_data.chosen_move) < MOVE_COUNT)
        else $error("chosen move out of range");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("ports active straight after reset");

endmodule

bind tabular_sarsa_update tsu_checker #(
    .MOVE_COUNT (MOVE_COUNT)
) u_tsu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### verif/tb_tabular_sarsa_update.sv
`timescale 1ns / 1ps

// Self-checking bench for the tabular SARSA engine.
// Beats go in on s_, results come out on m_, and the learning registers are
// written over cfg_. A predictor in this module keeps its own copy of the
// value table, the held state and move, and the registers, and works out the
// result of every input beat at the moment it is accepted.
module tb_tabular_sarsa_update;
    import tsu_pkg::*;

    localparam int COLUMN_BINS = COLUMN_BINS_DEF;
    localparam int ROW_BINS    = ROW_BINS_DEF;
    localparam int MOVE_COUNT  = MOVE_COUNT_DEF;
    localparam int STATE_COUNT = COLUMN_BINS * COLUMN_BINS * ROW_BINS;
    localparam int TABLE_DEPTH = STATE_COUNT * MOVE_COUNT;

    // Index that decodes to no register; a write there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int     IDLE_PERCENT  = 12;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     HOLD_CYCLES   = 400;  // long receiver hold-off
    localparam int     PHASE_ITEMS   = 100;
    localparam longint WATCHDOG_NS   = 4_000_000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    tsu_item_t              s_data;
    logic                   m_valid;
    logic                   m_ready;
    tsu_result_t            m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tabular_sarsa_update #(
        .COLUMN_BINS (COLUMN_BINS),
        .ROW_BINS    (ROW_BINS),
        .MOVE_COUNT  (MOVE_COUNT)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: its own value table, held pair and registers
    // ------------------------------------------------------------------
    shortint     q_table [TABLE_DEPTH];
    int unsigned held_state;
    int unsigned held_move_p;
    logic [16:0] tb_explore;
    logic [15:0] tb_alpha;
    logic [15:0] tb_discount;

    tsu_result_t expected_results[$];

    // Run statistics
    int n_items;
    int n_starts;
    int n_explored;
    int n_greedy;
    int n_saturated;
    int results_seen;
    int mismatches;

    // Shared idling controls
    bit steady_run;   // set: neither side idles
    int hold_left;    // receiver hold-off, counted down in cycles

    // Round x / 65536 to nearest, a half going up: floor((x + 2^15) / 2^16)
    function automatic longint round_frac16(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic int unsigned clamp_to(int unsigned v, int unsigned count);
        return (v >= count) ? count - 1 : v;
    endfunction

    // Predict one beat: choose the move, apply the SARSA update to the held
    // pair, then advance the held pair to the new state and move.
    function automatic tsu_result_t predict_sarsa_step(tsu_item_t it);
        tsu_result_t res;
        int unsigned col;
        int unsigned ocol;
        int unsigned orow;
        int unsigned rmove;
        int unsigned nstate;
        int unsigned nmove;
        int unsigned entry;
        bit          took_random;
        shortint     bestv;
        longint      q;
        longint      qn;
        longint      target;
        longint      step;
        longint      nv;

        col    = clamp_to(32'(it.next_column_bin), COLUMN_BINS);
        ocol   = clamp_to(32'(it.next_obstacle_column_bin), COLUMN_BINS);
        orow   = clamp_to(32'(it.next_obstacle_row_bin), ROW_BINS);
        rmove  = clamp_to(32'(it.random_move), MOVE_COUNT);
        nstate = (col * COLUMN_BINS + ocol) * ROW_BINS + orow;

        took_random = ({1'b0, it.explore_draw} < tb_explore);
        if (took_random) begin
            nmove = rmove;
        end else begin
            // Greedy over the table as it stands before this beat's write;
            // strict compare keeps the lowest index on ties
            nmove = 0;
            bestv = q_table[nstate * MOVE_COUNT];
            for (int m = 1; m < MOVE_COUNT; m++) begin
                if (q_table[nstate * MOVE_COUNT + m] > bestv) begin
                    bestv = q_table[nstate * MOVE_COUNT + m];
                    nmove = m;
                end
            end
        end

        nv = 0;
        if (!it.episode_start) begin
            entry  = held_state * MOVE_COUNT + held_move_p;
            q      = q_table[entry];
            qn     = q_table[nstate * MOVE_COUNT + nmove];
            target = longint'(it.reward) * 256 + round_frac16(longint'(tb_discount) * qn);
            step   = round_frac16(longint'(tb_alpha) * (target - q));
            nv     = q + step;
            if (nv > 32767) begin
                nv = 32767;
                n_saturated++;
            end
            if (nv < -32768) begin
                nv = -32768;
                n_saturated++;
            end
            q_table[entry] = shortint'(nv);
        end else begin
            n_starts++;
        end

        held_state  = nstate;
        held_move_p = nmove;
        if (took_random) n_explored++;
        else n_greedy++;

        res.chosen_move   = nmove[1:0];
        res.explored      = took_random;
        res.updated_value = nv[15:0];
        return res;
    endfunction

    function automatic tsu_item_t make_item(int start, int reward, int col, int ocol,
                                            int orow, int draw, int rmove);
        tsu_item_t it;
        it.episode_start            = start[0];
        it.reward                   = reward[7:0];
        it.next_column_bin          = col[3:0];
        it.next_obstacle_column_bin = ocol[3:0];
        it.next_obstacle_row_bin    = orow[3:0];
        it.explore_draw             = draw[15:0];
        it.random_move              = rmove[1:0];
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("timeout: %0d results still expected", expected_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: drive m_ready at the falling edge. A pending hold-off wins;
    // otherwise drop ready in about one cycle in eight, unless steady.
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare every accepted result beat with the oldest
    // expectation, field by field
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        tsu_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: move %0d explored %0b value %0d",
                             m_data.chosen_move, m_data.explored, m_data.updated_value);
            end else begin
                want = expected_results.pop_front();
                results_seen++;
                if (m_data.chosen_move !== want.chosen_move ||
                    m_data.explored !== want.explored ||
                    m_data.updated_value !== want.updated_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected move %0d explored %0b value %0d,",
                                  " got move %0d explored %0b value %0d"},
                                 results_seen, want.chosen_move, want.explored,
                                 want.updated_value, m_data.chosen_move, m_data.explored,
                                 m_data.updated_value);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one input beat, idling first now and then, and hold it until
    // it is taken; predict its result at the accepting edge
    task automatic send_item(input tsu_item_t it);
        int gap;
        @(negedge aclk);
        if (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_sarsa_step(it));
        n_items++;
    endtask

    // Drop valid after the last beat of a burst
    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Hold until every expected result has arrived, then let the engine settle
    task automatic wait_idle();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register; the predictor follows the same decode and masking
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_EXPLORE_RATE: tb_explore  = value[16:0];
            CFG_LEARN_RATE:   tb_alpha    = value[15:0];
            CFG_DISCOUNT:     tb_discount = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_settings(input int explore, input int alpha, input int disc);
        wait_idle();
        write_reg(CFG_EXPLORE_RATE, explore[CFG_DATA_W-1:0]);
        write_reg(CFG_LEARN_RATE, alpha[CFG_DATA_W-1:0]);
        write_reg(CFG_DISCOUNT, disc[CFG_DATA_W-1:0]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers explore every move; hit field extremes, bin and move
    // clamping, and a read of the very cell being updated
    task automatic test_reset_defaults();
        send_item(make_item(1, 0, 0, 0, 0, 65535, 3));
        send_item(make_item(0, 127, 15, 15, 15, 0, 0));
        send_item(make_item(0, -128, 9, 9, 9, 12345, 0));
        send_item(make_item(0, -128, 5, 10, 3, 40000, 1));
        send_item(make_item(1, 127, 12, 0, 9, 65535, 2));
        release_input();
    endtask

    // A write to an undecoded index is dropped; learn_rate keeps 16 bits only
    task automatic test_config_decode();
        wait_idle();
        write_reg(CFG_UNUSED_INDEX, '0);
        write_reg(CFG_LEARN_RATE, 17'h1FFFF);
        send_item(make_item(0, 64, 3, 4, 5, 65535, 1));
        send_item(make_item(0, -1, 3, 4, 5, 65535, 2));
        release_input();
    endtask

    // Explore rate zero: a zero draw must still go greedy; ties take the
    // lowest move, and repeated visits to one state shift the argmax
    task automatic test_greedy_ties();
        write_settings(0, 65535, 65535);
        send_item(make_item(1, 0, 1, 2, 3, 0, 2));
        send_item(make_item(0, -128, 1, 2, 3, 0, 2));
        send_item(make_item(0, -128, 1, 2, 3, 0, 2));
        send_item(make_item(0, 5, 1, 2, 3, 0, 2));
        send_item(make_item(0, 0, 1, 2, 3, 0, 2));
        send_item(make_item(0, -128, 1, 2, 3, 0, 2));
        release_input();
    endtask

    // Full alpha and gamma drive one cell into each saturation rail
    task automatic test_saturation();
        write_settings(65535, 65535, 65535);
        send_item(make_item(1, 0, 4, 4, 4, 0, 0));
        repeat (3) send_item(make_item(0, 127, 4, 4, 4, 0, 0));
        send_item(make_item(1, 0, 6, 7, 8, 0, 3));
        repeat (3) send_item(make_item(0, -128, 6, 7, 8, 0, 3));
        send_item(make_item(0, 0, 6, 7, 8, 65535, 0));
        release_input();
    endtask

    // Game-like episodes: the obstacle falls row by row, the player column
    // follows the chosen move, so states recur and the table fills in.
    // About one beat in ten is raw noise with unclamped fields.
    task automatic run_episodes(input int count);
        int        col;
        int        ocol;
        int        row;
        int        rwd;
        bit        fresh;
        tsu_item_t it;
        fresh = 1'b1;
        col   = 0;
        ocol  = 0;
        row   = 0;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 10) begin
                it = make_item($urandom_range(0, 1), $urandom_range(0, 255),
                               $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 65535),
                               $urandom_range(0, 3));
            end else if (fresh || row >= ROW_BINS - 1) begin
                col   = $urandom_range(0, COLUMN_BINS - 1);
                ocol  = $urandom_range(0, COLUMN_BINS - 1);
                row   = 0;
                fresh = 1'b0;
                it = make_item(1, $urandom_range(0, 255), col, ocol, row,
                               $urandom_range(0, 65535), $urandom_range(0, 2));
            end else begin
                col = col + int'(held_move_p) - 1;
                if (col < 0) col = 0;
                if (col > COLUMN_BINS - 1) col = COLUMN_BINS - 1;
                row++;
                if (row == ROW_BINS - 1 && col == ocol) rwd = -100;
                else if ($urandom_range(0, 15) == 0) rwd = $urandom_range(0, 255);
                else rwd = 1;
                it = make_item(0, rwd, col, ocol, row, $urandom_range(0, 65535),
                               $urandom_range(0, 2));
            end
            send_item(it);
        end
        release_input();
    endtask

    // Several register settings, the extremes among them; one phase runs
    // with no idling on either side
    task automatic test_random_episodes();
        write_settings(65536, 6554, 58982);
        run_episodes(PHASE_ITEMS);
        write_settings(6554, 6554, 58982);
        run_episodes(PHASE_ITEMS);
        write_settings(0, 65535, 65535);
        steady_run = 1'b1;
        run_episodes(PHASE_ITEMS);
        wait_idle();
        steady_run = 1'b0;
        write_settings(65535, 0, 0);
        run_episodes(PHASE_ITEMS);
        write_settings(20000, 40000, 30000);
        run_episodes(PHASE_ITEMS);
    endtask

    // Hold the receiver off for a long stretch while beats keep coming, so
    // the queue fills and s_ready drops
    task automatic test_backpressure();
        wait_idle();
        @(posedge aclk);
        hold_left = HOLD_CYCLES;
        run_episodes(40);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        steady_run = 1'b0;
        hold_left  = 0;

        foreach (q_table[i]) q_table[i] = 16'sd0;
        held_state  = 0;
        held_move_p = 0;
        tb_explore  = EXPLORE_RATE_RESET;
        tb_alpha    = LEARN_RATE_RESET;
        tb_discount = DISCOUNT_RESET;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // s_ready stays low through the table clear; the sender just waits
        test_reset_defaults();
        test_config_decode();
        test_greedy_ties();
        test_saturation();
        test_random_episodes();
        test_backpressure();
        wait_idle();

        $display("covered %0d input beats (%0d episode starts) and %0d result beats",
                 n_items, n_starts, results_seen);
        $display("moves: %0d explored, %0d greedy; %0d saturated updates; %0d mismatches",
                 n_explored, n_greedy, n_saturated, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### tabular_sarsa_update.f
rtl/core/tsu_pkg.sv
rtl/core/tsu_front.sv
rtl/core/tsu_queue.sv
rtl/core/tsu_back.sv
rtl/core/tabular_sarsa_update.sv
rtl/core/tsu_checker.sv
verif/tb_tabular_sarsa_update.sv
